[rtl/core/stack_machine_execute_unit_top_defines.svh]
// Assertion macros for the stack machine execute unit.
// Included by the RTL files that carry assertions; depends on nothing else.
`ifndef STACK_MACHINE_EXECUTE_UNIT_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_TOP_DEFINES_SVH
`ifndef SYNTH
`define SMEU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`define SMEU_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);
`else
`define SMEU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define SMEU_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/core/smeu_pkg.sv]
// Shared constants, opcodes and types of the stack machine execute unit.
// Used by the interfaces, the stack cells, the stack row and the top level.
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;
	localparam int WORD_W   = 32;
	localparam int ACTION_W = 4;
	localparam int PC_W     = 8;
	localparam int DEPTH_W  = 7;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 8;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int PROGRAM_DEPTH   = 128;

	localparam logic [PC_W-1:0] PC_MAX = {PC_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_CLAMP =
		(PROGRAM_DEPTH > 255) ? LEN_W'(255) : LEN_W'(PROGRAM_DEPTH);

	localparam logic [ACTION_W-1:0] OP_PUSH  = 4'd0;
	localparam logic [ACTION_W-1:0] OP_POP   = 4'd1;
	localparam logic [ACTION_W-1:0] OP_ADD   = 4'd2;
	localparam logic [ACTION_W-1:0] OP_ADDI  = 4'd3;
	localparam logic [ACTION_W-1:0] OP_MUL   = 4'd4;
	localparam logic [ACTION_W-1:0] OP_JUMP  = 4'd5;
	localparam logic [ACTION_W-1:0] OP_SWAP  = 4'd6;
	localparam logic [ACTION_W-1:0] OP_BEQZ  = 4'd7;
	localparam logic [ACTION_W-1:0] OP_LOAD  = 4'd8;
	localparam logic [ACTION_W-1:0] OP_STORE = 4'd9;
	localparam logic [ACTION_W-1:0] OP_DUP   = 4'd10;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADJ  = 2'd3;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_FROM_UP,
		CM_FROM_DN
	} cell_mode_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic swap;
		logic write_top;
	} stack_ctl_t;
endpackage
`default_nettype wire

[rtl/core/smeu_ifs.sv]
// Valid/ready channel interfaces: instruction in, result out, and configuration.
// Depends on smeu_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface smeu_in_if;
	import smeu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [WORD_W-1:0]   argument;
	modport source (output valid, action, argument, input ready);
	modport sink (input valid, action, argument, output ready);
endinterface

interface smeu_out_if;
	import smeu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [PC_W-1:0]            next_pc;
	logic signed [WORD_W-1:0]   top_value;
	logic [DEPTH_W-1:0]         stack_depth;
	logic [STATUS_W-1:0]        status;
	logic                       halted;
	modport source (output valid, next_pc, top_value, stack_depth, status, halted,
		input ready);
	modport sink (input valid, next_pc, top_value, stack_depth, status, halted,
		output ready);
endinterface

interface smeu_cfg_if;
	import smeu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [LEN_W-1:0]           program_length;
	modport source (output valid, program_length, input ready);
	modport sink (input valid, program_length, output ready);
endinterface
`default_nettype wire

[rtl/core/smeu_cell.sv]
// One stack cell: holds a word and loads it from its shallower or deeper neighbor.
// Depends on smeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smeu_cell (
	input  wire                          clk,
	input  smeu_pkg::cell_mode_t         mode,
	input  wire [smeu_pkg::WORD_W-1:0]   up_d,
	input  wire [smeu_pkg::WORD_W-1:0]   dn_d,
	output logic [smeu_pkg::WORD_W-1:0]  word_q
);
	import smeu_pkg::*;

	always_ff @(posedge clk) begin
		unique case (mode)
			CM_FROM_UP: word_q <= up_d;
			CM_FROM_DN: word_q <= dn_d;
			default:    word_q <= word_q;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/smeu_stack_row.sv]
// Operand stack as a row of cells with the top of stack in cell zero.
// Depends on smeu_pkg and smeu_cell.
`timescale 1ns / 1ps
`default_nettype none
module smeu_stack_row #(
	parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF
) (
	input  wire                          clk,
	input  smeu_pkg::stack_ctl_t         ctl,
	input  wire [smeu_pkg::WORD_W-1:0]   new_top,
	output logic [smeu_pkg::WORD_W-1:0]  top_word,
	output logic [smeu_pkg::WORD_W-1:0]  second_word
);
	import smeu_pkg::*;

	logic [WORD_W-1:0] cell_word [STACK_DEPTH];
	cell_mode_t        cell_mode [STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] up_w;
		logic [WORD_W-1:0] dn_w;

		if (i == 0) begin : g_top
			assign up_w = new_top;
			always_comb begin
				priority if (ctl.write_top) cell_mode[i] = CM_FROM_UP;
				else if (ctl.pop || ctl.swap) cell_mode[i] = CM_FROM_DN;
				else cell_mode[i] = CM_HOLD;
			end
		end else begin : g_lower
			assign up_w = cell_word[i-1];
			always_comb begin
				priority if (ctl.push || (ctl.swap && i == 1)) cell_mode[i] = CM_FROM_UP;
				else if (ctl.pop) cell_mode[i] = CM_FROM_DN;
				else cell_mode[i] = CM_HOLD;
			end
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign dn_w = '0;
		end else begin : g_inner
			assign dn_w = cell_word[i+1];
		end

		smeu_cell u_cell (
			.clk    (clk),
			.mode   (cell_mode[i]),
			.up_d   (up_w),
			.dn_d   (dn_w),
			.word_q (cell_word[i])
		);
	end

	assign top_word    = cell_word[0];
	assign second_word = cell_word[1];
endmodule
`default_nettype wire

[rtl/core/stack_machine_execute_unit_top.sv]
// Top level of the stack machine execute unit: input register, decode, ALU,
// program counter, store register and result register around the stack row.
// Depends on smeu_pkg, smeu_ifs, smeu_stack_row and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_unit_top_defines.svh"
// Executes one stack-machine instruction per item and returns one result item with
// the next pc, top of stack, depth, status and halted flag. An item waits in the
// input register until the result register is free or being taken, is then executed
// against the stack, and its result item is presented from the next cycle; a new item
// is accepted every cycle while the result side keeps up. The operand stack is a row
// of STACK_DEPTH cells that shift together on a push or pop, and MUL finishes in the
// execute cycle. Stack errors and bad jump targets leave all state unchanged, and no
// clearing pass is needed. The user is to write the program length register through
// the configuration channel only while the unit is idle; the block does not enforce it.
module stack_machine_execute_unit_top #(
	parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF
) (
	input wire         clk,
	input wire         arst_n,
	smeu_cfg_if.sink   cfg,
	smeu_in_if.sink    instr,
	smeu_out_if.source result
);
	import smeu_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic                  valid_s1;
	logic [ACTION_W-1:0]   action_s1;
	logic [WORD_W-1:0]     argument_s1;

	logic [CNT_W-1:0]      count_q;
	logic [PC_W-1:0]       pc_q;
	logic [WORD_W-1:0]     store_q;
	logic [LEN_W-1:0]      eff_len_q;

	logic                  out_valid_q;
	logic [PC_W-1:0]       next_pc_q;
	logic [WORD_W-1:0]     top_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  halted_q;

	logic                  exec_fire;
	logic                  commit;
	logic [1:0]            need;
	logic                  growth;
	logic                  known_op;
	logic                  is_jump;
	logic                  is_beqz;
	logic                  target_ok;
	logic [STATUS_W-1:0]   status_c;
	stack_ctl_t            ctl_c;
	stack_ctl_t            ctl_gated;
	logic [WORD_W-1:0]     top_w;
	logic [WORD_W-1:0]     second_w;
	logic [WORD_W-1:0]     new_top;
	logic [WORD_W-1:0]     product;
	logic [PC_W-1:0]       pc_inc;
	logic [PC_W-1:0]       pc_nxt;
	logic [CNT_W-1:0]      count_nxt;
	logic [WORD_W-1:0]     top_nxt;
	logic [CNT_W+DEPTH_W-1:0] count_ext;

	assign exec_fire   = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || exec_fire;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			action_s1   <= instr.action;
			argument_s1 <= instr.argument;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			eff_len_q <= (cfg.program_length < LEN_CLAMP) ? cfg.program_length : LEN_CLAMP;
		end
	end

	always_comb begin
		need     = 2'd0;
		growth   = 1'b0;
		known_op = 1'b1;
		is_jump  = 1'b0;
		is_beqz  = 1'b0;
		ctl_c    = '0;
		new_top  = top_w;
		unique case (action_s1)
			OP_PUSH: begin
				growth = 1'b1;
				ctl_c.push = 1'b1;
				ctl_c.write_top = 1'b1;
				new_top = argument_s1;
			end
			OP_POP: begin
				need = 2'd1;
				ctl_c.pop = 1'b1;
			end
			OP_ADD: begin
				need = 2'd2;
				ctl_c.pop = 1'b1;
				ctl_c.write_top = 1'b1;
				new_top = top_w + second_w;
			end
			OP_ADDI: begin
				need = 2'd1;
				ctl_c.write_top = 1'b1;
				new_top = top_w + argument_s1;
			end
			OP_MUL: begin
				need = 2'd2;
				ctl_c.pop = 1'b1;
				ctl_c.write_top = 1'b1;
				new_top = product;
			end
			OP_JUMP: begin
				is_jump = 1'b1;
			end
			OP_SWAP: begin
				need = 2'd2;
				ctl_c.swap = 1'b1;
			end
			OP_BEQZ: begin
				need = 2'd1;
				is_beqz = 1'b1;
			end
			OP_LOAD: begin
				growth = 1'b1;
				ctl_c.push = 1'b1;
				ctl_c.write_top = 1'b1;
				new_top = store_q;
			end
			OP_STORE: begin
				need = 2'd1;
				ctl_c.pop = 1'b1;
			end
			OP_DUP: begin
				need = 2'd1;
				growth = 1'b1;
				ctl_c.push = 1'b1;
				ctl_c.write_top = 1'b1;
				new_top = top_w;
			end
			default: begin
				known_op = 1'b0;
			end
		endcase
	end

	assign product   = top_w * second_w;
	assign target_ok = (argument_s1[WORD_W-1:PC_W] == '0)
		&& (argument_s1[PC_W-1:0] < eff_len_q);

	always_comb begin
		priority if ((is_jump || is_beqz) && !target_ok) status_c = ST_BADJ;
		else if (count_q < CNT_W'(need)) status_c = ST_UNDER;
		else if (growth && count_q == CNT_W'(STACK_DEPTH)) status_c = ST_OVER;
		else status_c = ST_OK;
	end

	assign commit    = exec_fire && known_op && status_c == ST_OK;
	assign ctl_gated = commit ? ctl_c : '0;
	assign pc_inc    = (pc_q == PC_MAX) ? pc_q : pc_q + PC_W'(1);

	always_comb begin
		pc_nxt    = pc_q;
		count_nxt = count_q;
		top_nxt   = top_w;
		if (commit) begin
			priority if (is_jump || (is_beqz && top_w == '0)) pc_nxt = argument_s1[PC_W-1:0];
			else pc_nxt = pc_inc;
			priority if (ctl_c.push) count_nxt = count_q + CNT_W'(1);
			else if (ctl_c.pop) count_nxt = count_q - CNT_W'(1);
			else count_nxt = count_q;
			priority if (ctl_c.write_top) top_nxt = new_top;
			else if (ctl_c.pop || ctl_c.swap) top_nxt = second_w;
			else top_nxt = top_w;
		end
		if (count_nxt == '0) begin
			top_nxt = '0;
		end
	end

	assign count_ext = {{DEPTH_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pc_q    <= '0;
			store_q <= '0;
		end else if (commit) begin
			count_q <= count_nxt;
			pc_q    <= pc_nxt;
			if (action_s1 == OP_STORE) begin
				store_q <= top_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			next_pc_q <= pc_nxt;
			top_q     <= top_nxt;
			depth_q   <= count_ext[DEPTH_W-1:0];
			status_q  <= status_c;
			halted_q  <= (pc_nxt >= eff_len_q);
		end
	end

	smeu_stack_row #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack_row (
		.clk         (clk),
		.ctl         (ctl_gated),
		.new_top     (new_top),
		.top_word    (top_w),
		.second_word (second_w)
	);

	assign result.valid       = out_valid_q;
	assign result.next_pc     = next_pc_q;
	assign result.top_value   = top_q;
	assign result.stack_depth = depth_q;
	assign result.status      = status_q;
	assign result.halted      = halted_q;

	`SMEU_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(STACK_DEPTH),
		"Stack count exceeds the stack depth.")
	`SMEU_ASSERT_NEXT(a_error_holds, clk, arst_n, exec_fire && status_c != ST_OK,
		count_q == $past(count_q) && pc_q == $past(pc_q),
		"A failed instruction changed the machine state.")
	`SMEU_ASSERT_NEXT(a_exec_gives_result, clk, arst_n, exec_fire, out_valid_q,
		"An executed instruction produced no result item.")
	`SMEU_ASSERT_IMPLY(a_underflow_cause, clk, arst_n, exec_fire && status_c == ST_UNDER,
		count_q < CNT_W'(2), "Underflow reported with two or more entries on the stack.")
endmodule
`default_nettype wire

[tb/stack_machine_execute_unit_top_test.sv]
// Testbench for the stack machine execute unit: directed and random instruction items
// checked against a shadow machine. Depends on smeu_pkg, smeu_ifs and the top level.
`timescale 1ns / 1ps
module stack_machine_execute_unit_top_test;
	import smeu_pkg::*;

	localparam int STACK_N = STACK_DEPTH_DEF;

	typedef struct packed {
		logic [PC_W-1:0]     next_pc;
		logic [WORD_W-1:0]   top_value;
		logic [DEPTH_W-1:0]  stack_depth;
		logic [STATUS_W-1:0] status;
		logic                halted;
	} step_report_t;

	logic clk = 1'b0;
	logic arst_n;

	smeu_cfg_if cfg_ch();
	smeu_in_if  instr_ch();
	smeu_out_if result_ch();

	stack_machine_execute_unit_top #(.STACK_DEPTH(STACK_N)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.instr  (instr_ch),
		.result (result_ch)
	);

	logic [WORD_W-1:0] shadow_stack [STACK_N];
	int                shadow_count;
	int                shadow_pc;
	logic [WORD_W-1:0] shadow_store;
	int                shadow_length;
	step_report_t      pending_reports [$];
	int                error_count = 0;
	bit                send_idle;
	bit                recv_idle;

	always #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int effective_length();
		return (shadow_length < PROGRAM_DEPTH) ? shadow_length : PROGRAM_DEPTH;
	endfunction

	task automatic execute_on_shadow(input logic [ACTION_W-1:0] act,
		input logic [WORD_W-1:0] arg);
		int                  need;
		int                  growth;
		int                  eff;
		int                  n;
		logic [STATUS_W-1:0] st;
		logic [WORD_W-1:0]   tmp;
		step_report_t        rep;
		eff = effective_length();
		need = 0;
		growth = 0;
		n = shadow_count;
		case (act)
			OP_PUSH, OP_LOAD: growth = 1;
			OP_POP, OP_ADDI, OP_STORE, OP_BEQZ: need = 1;
			OP_ADD, OP_MUL, OP_SWAP: need = 2;
			OP_DUP: begin
				need = 1;
				growth = 1;
			end
			default: ;
		endcase
		if ((act == OP_JUMP || act == OP_BEQZ) && (arg[31] || int'(arg) >= eff))
			st = ST_BADJ;
		else if (n < need)
			st = ST_UNDER;
		else if (growth != 0 && n >= STACK_N)
			st = ST_OVER;
		else
			st = ST_OK;
		if (st == ST_OK && act <= OP_DUP) begin
			case (act)
				OP_PUSH: begin
					shadow_stack[n] = arg;
					shadow_count = n + 1;
				end
				OP_POP: shadow_count = n - 1;
				OP_ADD: begin
					shadow_stack[n-2] = shadow_stack[n-1] + shadow_stack[n-2];
					shadow_count = n - 1;
				end
				OP_ADDI: shadow_stack[n-1] = shadow_stack[n-1] + arg;
				OP_MUL: begin
					shadow_stack[n-2] = shadow_stack[n-1] * shadow_stack[n-2];
					shadow_count = n - 1;
				end
				OP_SWAP: begin
					tmp = shadow_stack[n-1];
					shadow_stack[n-1] = shadow_stack[n-2];
					shadow_stack[n-2] = tmp;
				end
				OP_LOAD: begin
					shadow_stack[n] = shadow_store;
					shadow_count = n + 1;
				end
				OP_STORE: begin
					shadow_store = shadow_stack[n-1];
					shadow_count = n - 1;
				end
				OP_DUP: begin
					shadow_stack[n] = shadow_stack[n-1];
					shadow_count = n + 1;
				end
				default: ;
			endcase
			if (act == OP_JUMP || (act == OP_BEQZ && shadow_stack[n-1] == '0))
				shadow_pc = int'(arg);
			else
				shadow_pc = (shadow_pc >= 255) ? 255 : shadow_pc + 1;
		end
		rep.next_pc = shadow_pc[PC_W-1:0];
		rep.top_value = (shadow_count != 0) ? shadow_stack[shadow_count-1] : '0;
		rep.stack_depth = shadow_count[DEPTH_W-1:0];
		rep.status = st;
		rep.halted = (shadow_pc >= eff);
		pending_reports.push_back(rep);
	endtask

	task automatic send_instr(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] arg);
		int gap;
		if ($urandom_range(0, 29) == 0) begin
			send_idle = ($urandom_range(0, 2) != 0);
			recv_idle = ($urandom_range(0, 2) != 0);
		end
		gap = send_idle ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.action <= act;
		instr_ch.argument <= arg;
		do @(posedge clk); while (!instr_ch.ready);
		execute_on_shadow(act, arg);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_program_length(input logic [LEN_W-1:0] len);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.program_length <= len;
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_length = int'(len);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 4);
			1: return ~WORD_W'($urandom_range(0, 3));
			2: begin
				case ($urandom_range(0, 2))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] branch_target();
		int eff;
		eff = effective_length();
		if (eff > 0 && $urandom_range(0, 3) != 0)
			return $urandom_range(0, eff - 1);
		case ($urandom_range(0, 2))
			0: return eff;
			1: return ~WORD_W'($urandom_range(0, 1));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_op(input bit branches);
		logic [ACTION_W-1:0] act;
		logic [WORD_W-1:0]   arg;
		if ($urandom_range(0, 19) == 0)
			act = ACTION_W'($urandom_range(11, 15));
		else if (shadow_count < 2 && $urandom_range(0, 1) != 0)
			act = OP_PUSH;
		else
			act = ACTION_W'($urandom_range(0, 10));
		if (!branches && (act == OP_JUMP || act == OP_BEQZ))
			act = OP_ADDI;
		arg = (act == OP_JUMP || act == OP_BEQZ) ? branch_target() : random_word();
		send_instr(act, arg);
	endtask

	// Program length is still zero here, so every target is out of range.
	task automatic test_after_reset();
		send_instr(OP_BEQZ, 32'd0);
		send_instr(OP_JUMP, 32'd0);
		send_instr(OP_POP, 32'd0);
		send_instr(OP_LOAD, 32'd0);
		send_instr(4'd15, 32'hffff_ffff);
		send_instr(4'd11, 32'd0);
	endtask

	task automatic test_arith();
		write_program_length(LEN_W'(128));
		send_instr(OP_PUSH, 32'h7fff_ffff);
		send_instr(OP_PUSH, 32'd1);
		send_instr(OP_ADD, 32'd0);
		send_instr(OP_ADDI, 32'hffff_ffff);
		send_instr(OP_PUSH, 32'h8000_0000);
		send_instr(OP_MUL, 32'd0);
		send_instr(OP_DUP, 32'd0);
		send_instr(OP_SWAP, 32'd0);
		send_instr(OP_STORE, 32'd0);
		send_instr(OP_LOAD, 32'd0);
		send_instr(OP_ADDI, 32'h8000_0000);
	endtask

	task automatic test_branches();
		write_program_length(LEN_W'(1));
		send_instr(OP_JUMP, 32'd0);
		send_instr(OP_JUMP, 32'd1);
		send_instr(OP_JUMP, 32'hffff_ffff);
		send_instr(OP_PUSH, 32'd0);
		send_instr(OP_BEQZ, 32'd0);
		send_instr(OP_ADDI, 32'd5);
		send_instr(OP_BEQZ, 32'd0);
		write_program_length(LEN_W'(255));
		send_instr(OP_JUMP, 32'd127);
		send_instr(OP_JUMP, 32'd128);
		send_instr(OP_JUMP, 32'h8000_0000);
	endtask

	task automatic test_stack_extremes();
		logic [ACTION_W-1:0] act;
		write_program_length(LEN_W'(128));
		while (shadow_count < STACK_N) begin
			case ($urandom_range(0, 2))
				0: act = OP_PUSH;
				1: act = OP_LOAD;
				default: act = OP_DUP;
			endcase
			send_instr(act, random_word());
		end
		send_instr(OP_PUSH, random_word());
		send_instr(OP_LOAD, 32'd0);
		send_instr(OP_DUP, 32'd0);
		send_instr(OP_SWAP, 32'd0);
		send_instr(OP_ADD, 32'd0);
		send_instr(OP_DUP, 32'd0);
		send_instr(OP_DUP, 32'd0);
		while (shadow_count > 1) begin
			case ($urandom_range(0, 4))
				0: act = OP_POP;
				1: act = OP_ADD;
				2: act = OP_MUL;
				3: act = OP_STORE;
				default: act = OP_ADDI;
			endcase
			send_instr(act, random_word());
		end
		send_instr(OP_SWAP, 32'd0);
		send_instr(OP_ADD, 32'd0);
		send_instr(OP_MUL, 32'd0);
		send_instr(OP_POP, 32'd0);
		send_instr(OP_POP, 32'd0);
		send_instr(OP_ADDI, 32'd1);
		send_instr(OP_STORE, 32'd0);
		send_instr(OP_DUP, 32'd0);
		send_instr(OP_BEQZ, 32'd3);
	endtask

	// The pc starts from the highest legal target and counts up until it saturates.
	task automatic test_pc_limit();
		int guard;
		guard = 0;
		write_program_length(LEN_W'(128));
		send_instr(OP_JUMP, 32'd127);
		while (shadow_pc < 255 && guard < 400) begin
			send_random_op(1'b0);
			guard++;
		end
		repeat (5) send_random_op(1'b0);
	endtask

	task automatic test_random_mix();
		write_program_length(LEN_W'(0));
		repeat (20) send_random_op(1'b1);
		write_program_length(LEN_W'($urandom_range(2, 8)));
		repeat (20) send_random_op(1'b1);
		write_program_length(LEN_W'($urandom_range(0, 255)));
		repeat (20) send_random_op(1'b1);
		write_program_length(LEN_W'(255));
		repeat (20) send_random_op(1'b1);
	endtask

	initial begin : result_sink
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_idle ? $urandom_range(0, 10) : 0;
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	always @(posedge clk) begin : result_check
		step_report_t got;
		step_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.next_pc = result_ch.next_pc;
			got.top_value = result_ch.top_value;
			got.stack_depth = result_ch.stack_depth;
			got.status = result_ch.status;
			got.halted = result_ch.halted;
			if (pending_reports.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected result item pc=%0d top=%h depth=%0d status=%0d",
						$realtime, got.next_pc, got.top_value, got.stack_depth, got.status);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= 10)
						$display({"%0t: mismatch expected pc=%0d top=%h depth=%0d st=%0d ",
							"halt=%0b, got pc=%0d top=%h depth=%0d st=%0d halt=%0b"}, $realtime,
							want.next_pc, want.top_value, want.stack_depth, want.status,
							want.halted, got.next_pc, got.top_value, got.stack_depth,
							got.status, got.halted);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.action = '0;
		instr_ch.argument = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.program_length = '0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		shadow_count = 0;
		shadow_pc = 0;
		shadow_store = '0;
		shadow_length = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_after_reset();
		test_arith();
		test_branches();
		test_stack_extremes();
		test_pc_limit();
		test_random_mix();
		wait_drained();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
